// ----- design/guillotine_rect_allocator_core_macros.svh -----
// ----------------------------------------------------------------------------
// guillotine rect allocator assertion macros
// short forms for the concurrent checks in the design
// ----------------------------------------------------------------------------
`ifndef GUILLOTINE_RECT_ALLOCATOR_CORE_MACROS_SVH
`define GUILLOTINE_RECT_ALLOCATOR_CORE_MACROS_SVH

// condition holds at every clock edge out of reset
`define GRAC_ASSERT(lbl, cond) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
	else $error("grac assertion failed");

// antecedent implies consequent in the same cycle
`define GRAC_ASSERT_IMP(lbl, ante, cons) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("grac implication failed");

`endif

// ----- design/grac_pkg.sv -----
// ----------------------------------------------------------------------------
// grac_pkg
// shared types and constants of the guillotine rect allocator
// ----------------------------------------------------------------------------
package grac_pkg;

	localparam int FREE_SLOTS = 256;
	localparam int SLOT_W     = $clog2(FREE_SLOTS);
	localparam int CNT_W      = SLOT_W + 1;
	localparam int MAX_DIM    = 4096;
	localparam int DIM_W      = $clog2(MAX_DIM) + 1;
	localparam int POS_W      = $clog2(MAX_DIM);
	localparam int GRP        = 8;
	localparam int GRP_LW     = $clog2(GRP);
	localparam int GRP_W      = SLOT_W - GRP_LW;

	// response status codes
	localparam logic [1:0] RSP_PLACED  = 2'd0;
	localparam logic [1:0] RSP_NOFIT   = 2'd1;
	localparam logic [1:0] RSP_FULL    = 2'd2;
	localparam logic [1:0] RSP_CLEARED = 2'd3;

	// shared unit operations
	localparam logic ALU_ADD = 1'b0;
	localparam logic ALU_SUB = 1'b1;

	// configuration register indexes
	localparam logic CFG_ATLAS_W = 1'b0;
	localparam logic CFG_ATLAS_H = 1'b1;

	typedef struct packed {
		logic             req_type;
		logic [DIM_W-1:0] req_width;
		logic [DIM_W-1:0] req_height;
		logic             split_choice;
	} req_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [POS_W-1:0] pos_x;
		logic [POS_W-1:0] pos_y;
	} rsp_t;

	typedef struct packed {
		logic [POS_W-1:0] left;
		logic [POS_W-1:0] top;
		logic [DIM_W-1:0] wide;
		logic [DIM_W-1:0] tall;
	} rect_t;

	typedef struct packed {
		logic [SLOT_W-1:0] first;
		logic [SLOT_W-1:0] second;
	} alt_t;

	typedef struct packed {
		logic             op;
		logic [DIM_W-1:0] a;
		logic [DIM_W-1:0] b;
	} alu_req_t;

endpackage

// ----- design/grac_alu.sv -----
// ----------------------------------------------------------------------------
// grac_alu
// shared add / subtract-compare unit for fit tests and split geometry
// ----------------------------------------------------------------------------
module grac_alu import grac_pkg::*; (
	input  alu_req_t         cmd,
	output logic [DIM_W-1:0] res,
	output logic             borrow
);

	logic [DIM_W:0] sum;

	always_comb begin
		if (cmd.op == ALU_SUB) begin
			sum = {1'b0, cmd.a} - {1'b0, cmd.b};
		end else begin
			sum = {1'b0, cmd.a} + {1'b0, cmd.b};
		end
		res    = sum[DIM_W-1:0];
		// a < b on subtract
		borrow = sum[DIM_W];
	end

endmodule

// ----- design/guillotine_rect_allocator_core.sv -----
// ----------------------------------------------------------------------------
// guillotine_rect_allocator_core
// first-fit guillotine allocator over a ring of free rectangles
// ----------------------------------------------------------------------------
// usage
//   req channel (req_valid/req_ready/req): one word per request, allocate or
//   clear. rsp channel (rsp_valid/rsp_ready/rsp): exactly one word back per
//   request, status plus the placed position.
//   cfg port: cfg_we/cfg_index/cfg_data write atlas width (0) and height (1);
//   write only while the block is idle. clear uses the values clamped to 4096.
//   throughput: one request at a time; req_ready is high only when idle.
//   a clear rebuilds the full-atlas rectangle, then answers. allocate reads
//   each ring entry visited by the first-fit walk and tests its width, and
//   its height when the width fits, then runs the hit check, the unlink
//   steps, the geometry steps, a slot scan, write and ring append per new
//   piece, the link steps and the load; the free-slot scan checks 8 live
//   bits per cycle, spread across the four new pieces.
//   a miss or a full table answers after the walk or the hit check.
//   after reset the block writes the full-atlas rectangle into slot 0
//   before it raises req_ready.
//   a stalled receiver leaves the answer in the response register; a new
//   request may be taken meanwhile, its answer waits until that one leaves.
// ----------------------------------------------------------------------------
`include "guillotine_rect_allocator_core_macros.svh"

module guillotine_rect_allocator_core import grac_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	input  req_t             req,
	output logic             rsp_valid,
	input  logic             rsp_ready,
	output rsp_t             rsp,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [DIM_W-1:0] cfg_data
);

	// sequencer states
	localparam logic [4:0] S_INIT  = 5'd0;
	localparam logic [4:0] S_IDLE  = 5'd1;
	localparam logic [4:0] S_CLR   = 5'd2;
	localparam logic [4:0] S_SRD   = 5'd3;
	localparam logic [4:0] S_SCW   = 5'd4;
	localparam logic [4:0] S_SCH   = 5'd5;
	localparam logic [4:0] S_HIT   = 5'd6;
	localparam logic [4:0] S_ULRD  = 5'd7;
	localparam logic [4:0] S_ULWR  = 5'd8;
	localparam logic [4:0] S_PC    = 5'd9;
	localparam logic [4:0] S_SCAN  = 5'd10;
	localparam logic [4:0] S_APP   = 5'd11;
	localparam logic [4:0] S_TL    = 5'd12;
	localparam logic [4:0] S_WB    = 5'd13;
	localparam logic [4:0] S_LINK  = 5'd14;
	localparam logic [4:0] S_DONE  = 5'd15;

	localparam int CHK_W = CNT_W + 1;

	logic [4:0]             state_q;
	logic [DIM_W-1:0]       cfg_w_q, cfg_h_q;
	logic [FREE_SLOTS-1:0]  live_q, has_alt_q;
	logic [SLOT_W-1:0]      head_q;
	logic [CNT_W-1:0]       live_cnt_q;

	// request and working registers
	logic [DIM_W-1:0]       rw_q, rh_q;
	logic                   choice_q;
	logic [SLOT_W-1:0]      p_q, hit_q, a1_q, a2_q, slot_q, tail_q;
	logic [CNT_W-1:0]       i_q;
	logic [POS_W-1:0]       x_q, y_q, yd_q, xr_q;
	logic [DIM_W-1:0]       w_q, h_q, hd_q, wr_q;
	logic [1:0]             ul_sel_q, pc_cnt_q, app_k_q, lk_q;
	logic [GRP_W-1:0]       grp_q;
	logic [SLOT_W-1:0]      s0_q, s1_q, s2_q, s3_q;
	logic [1:0]             status_q;
	logic                   rsp_valid_q;
	rsp_t                   rsp_q;
	logic                   rsp_load;

	// memories
	rect_t                  rect_mem [FREE_SLOTS];
	logic [SLOT_W-1:0]      next_mem [FREE_SLOTS];
	logic [SLOT_W-1:0]      prev_mem [FREE_SLOTS];
	logic [SLOT_W-1:0]      part_mem [FREE_SLOTS];
	alt_t                   alt_mem  [FREE_SLOTS];

	rect_t                  rect_rd_q, rect_wd;
	logic [SLOT_W-1:0]      next_rd_q, prev_rd_q, part_rd_q;
	alt_t                   alt_rd_q, alt_wd;
	logic                   rect_we, rect_re, ptr_re, lk_re, lk_we;
	logic [SLOT_W-1:0]      rect_wa, rect_ra, ptr_ra, lk_ra, lk_wa, part_wd;
	logic                   next_we, prev_we;
	logic [SLOT_W-1:0]      next_wa, next_wd, prev_wa, prev_wd;

	// shared unit
	alu_req_t               alu_cmd;
	logic [DIM_W-1:0]       alu_res;
	logic                   alu_borrow;

	logic [DIM_W-1:0]       clamp_w, clamp_h;
	logic [SLOT_W-1:0]      ul_t;
	logic                   ul_go, tbl_full;
	logic [1:0]             piece_id;
	logic [GRP-1:0]         grp_live;
	logic [GRP_LW-1:0]      grp_low;
	logic                   grp_any;

	grac_alu u_alu (
		.cmd    (alu_cmd),
		.res    (alu_res),
		.borrow (alu_borrow)
	);

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// answer is ready and the response register is free or leaving
	assign rsp_load = (state_q == S_DONE) && (!rsp_valid_q || rsp_ready);

	// atlas size clamp for a clear
	assign clamp_w = (cfg_w_q > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : cfg_w_q;
	assign clamp_h = (cfg_h_q > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : cfg_h_q;

	// unlink target: alternate one, alternate two, then the hit itself
	always_comb begin
		case (ul_sel_q)
			2'd0:    ul_t = a1_q;
			2'd1:    ul_t = a2_q;
			default: ul_t = hit_q;
		endcase
		ul_go = (ul_sel_q == 2'd2) || (live_q[ul_t] && (ul_t != hit_q));
	end

	// would the split overflow the slot table
	always_comb begin
		tbl_full = (CHK_W'(live_cnt_q) + CHK_W'(4)) >
			(CHK_W'(FREE_SLOTS) + (has_alt_q[hit_q] ? CHK_W'(3) : CHK_W'(1)));
	end

	// lowest free slot inside the current group of eight
	always_comb begin
		grp_live = live_q[{grp_q, {GRP_LW{1'b0}}} +: GRP];
		grp_any  = 1'b0;
		grp_low  = '0;
		for (int k = GRP - 1; k >= 0; k--) begin
			if (!grp_live[k]) begin
				grp_any = 1'b1;
				grp_low = GRP_LW'(k);
			end
		end
	end

	// piece order flips with the split choice bit
	assign piece_id = app_k_q ^ {choice_q, 1'b0};

	always_comb begin
		rect_we = 1'b0; rect_wa = '0; rect_wd = '0;
		rect_re = 1'b0; rect_ra = '0;
		ptr_re  = 1'b0; ptr_ra  = '0;
		next_we = 1'b0; next_wa = '0; next_wd = '0;
		prev_we = 1'b0; prev_wa = '0; prev_wd = '0;
		lk_re   = 1'b0; lk_ra   = '0;
		lk_we   = 1'b0; lk_wa   = '0; part_wd = '0; alt_wd = '0;
		alu_cmd = '{op: ALU_SUB, a: '0, b: '0};
		unique case (state_q)
			S_INIT, S_CLR: begin
				rect_we = 1'b1;
				rect_wd = '{left: '0, top: '0, wide: clamp_w, tall: clamp_h};
				next_we = 1'b1;
				prev_we = 1'b1;
			end
			S_SRD: begin
				rect_re = 1'b1; rect_ra = p_q;
				ptr_re  = 1'b1; ptr_ra  = p_q;
			end
			S_SCW: alu_cmd = '{op: ALU_SUB, a: rect_rd_q.wide, b: rw_q};
			S_SCH: begin
				alu_cmd = '{op: ALU_SUB, a: rect_rd_q.tall, b: rh_q};
				lk_re   = 1'b1; lk_ra = p_q;
			end
			S_ULRD: begin
				ptr_re = ul_go; ptr_ra = ul_t;
			end
			S_ULWR: begin
				next_we = 1'b1; next_wa = prev_rd_q; next_wd = next_rd_q;
				prev_we = 1'b1; prev_wa = next_rd_q; prev_wd = prev_rd_q;
			end
			S_PC: begin
				case (pc_cnt_q)
					2'd0:    alu_cmd = '{op: ALU_ADD, a: {1'b0, y_q}, b: rh_q};
					2'd1:    alu_cmd = '{op: ALU_SUB, a: h_q, b: rh_q};
					2'd2:    alu_cmd = '{op: ALU_ADD, a: {1'b0, x_q}, b: rw_q};
					default: alu_cmd = '{op: ALU_SUB, a: w_q, b: rw_q};
				endcase
			end
			S_APP: begin
				rect_we = 1'b1; rect_wa = slot_q;
				case (piece_id)
					2'd0:    rect_wd = '{left: x_q,  top: yd_q, wide: w_q,  tall: hd_q};
					2'd1:    rect_wd = '{left: xr_q, top: y_q,  wide: wr_q, tall: rh_q};
					2'd2:    rect_wd = '{left: x_q,  top: yd_q, wide: rw_q, tall: hd_q};
					default: rect_wd = '{left: xr_q, top: y_q,  wide: wr_q, tall: h_q};
				endcase
				if (live_cnt_q == '0) begin
					// ring was empty: the piece links to itself
					next_we = 1'b1; next_wa = slot_q; next_wd = slot_q;
					prev_we = 1'b1; prev_wa = slot_q; prev_wd = slot_q;
				end else begin
					ptr_re = 1'b1; ptr_ra = head_q;
				end
			end
			S_TL: begin
				next_we = 1'b1; next_wa = prev_rd_q; next_wd = slot_q;
				prev_we = 1'b1; prev_wa = head_q;    prev_wd = slot_q;
			end
			S_WB: begin
				next_we = 1'b1; next_wa = slot_q; next_wd = head_q;
				prev_we = 1'b1; prev_wa = slot_q; prev_wd = tail_q;
			end
			S_LINK: begin
				lk_we = 1'b1;
				case (lk_q)
					2'd0: begin lk_wa = s0_q; part_wd = s1_q; alt_wd = '{s2_q, s3_q}; end
					2'd1: begin lk_wa = s1_q; part_wd = s0_q; alt_wd = '{s2_q, s3_q}; end
					2'd2: begin lk_wa = s2_q; part_wd = s3_q; alt_wd = '{s0_q, s1_q}; end
					default: begin lk_wa = s3_q; part_wd = s2_q; alt_wd = '{s0_q, s1_q}; end
				endcase
			end
			default: ;
		endcase
	end

	// memory ports, registered read data
	always_ff @(posedge clk) begin
		if (rect_we) rect_mem[rect_wa] <= rect_wd;
		if (rect_re) rect_rd_q <= rect_mem[rect_ra];
	end

	always_ff @(posedge clk) begin
		if (next_we) next_mem[next_wa] <= next_wd;
		if (ptr_re)  next_rd_q <= next_mem[ptr_ra];
	end

	always_ff @(posedge clk) begin
		if (prev_we) prev_mem[prev_wa] <= prev_wd;
		if (ptr_re)  prev_rd_q <= prev_mem[ptr_ra];
	end

	always_ff @(posedge clk) begin
		if (lk_we) part_mem[lk_wa] <= part_wd;
		if (lk_re) part_rd_q <= part_mem[lk_ra];
	end

	always_ff @(posedge clk) begin
		if (lk_we) alt_mem[lk_wa] <= alt_wd;
		if (lk_re) alt_rd_q <= alt_mem[lk_ra];
	end

	// control sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			rsp_valid_q <= 1'b0;
			cfg_w_q     <= DIM_W'(512);
			cfg_h_q     <= DIM_W'(512);
			live_q      <= FREE_SLOTS'(1);
			has_alt_q   <= '0;
			head_q      <= '0;
			live_cnt_q  <= CNT_W'(1);
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_ATLAS_W: cfg_w_q <= cfg_data;
					CFG_ATLAS_H: cfg_h_q <= cfg_data;
					default: ;
				endcase
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_INIT: begin
					live_q     <= FREE_SLOTS'(1);
					has_alt_q  <= '0;
					head_q     <= '0;
					live_cnt_q <= CNT_W'(1);
					state_q    <= S_IDLE;
				end
				S_IDLE: begin
					if (req_valid) begin
						rw_q     <= req.req_width;
						rh_q     <= req.req_height;
						choice_q <= req.split_choice;
						p_q      <= head_q;
						i_q      <= '0;
						state_q  <= req.req_type ? S_CLR : S_SRD;
					end
				end
				S_CLR: begin
					live_q     <= FREE_SLOTS'(1);
					has_alt_q  <= '0;
					head_q     <= '0;
					live_cnt_q <= CNT_W'(1);
					status_q   <= RSP_CLEARED;
					state_q    <= S_DONE;
				end
				S_SRD: begin
					// walked the whole ring without a fit
					if (i_q < live_cnt_q) begin
						state_q <= S_SCW;
					end else begin
						status_q <= RSP_NOFIT;
						state_q  <= S_DONE;
					end
				end
				S_SCW: begin
					if (!alu_borrow && live_q[p_q]) begin
						state_q <= S_SCH;
					end else begin
						p_q     <= next_rd_q;
						i_q     <= i_q + CNT_W'(1);
						state_q <= S_SRD;
					end
				end
				S_SCH: begin
					if (!alu_borrow) begin
						hit_q   <= p_q;
						x_q     <= rect_rd_q.left;
						y_q     <= rect_rd_q.top;
						w_q     <= rect_rd_q.wide;
						h_q     <= rect_rd_q.tall;
						state_q <= S_HIT;
					end else begin
						p_q     <= next_rd_q;
						i_q     <= i_q + CNT_W'(1);
						state_q <= S_SRD;
					end
				end
				S_HIT: begin
					if (tbl_full) begin
						status_q <= RSP_FULL;
						state_q  <= S_DONE;
					end else begin
						if (has_alt_q[hit_q]) begin
							// drop the other split pair, partner loses its mark
							a1_q                 <= alt_rd_q.first;
							a2_q                 <= alt_rd_q.second;
							has_alt_q[part_rd_q] <= 1'b0;
							ul_sel_q             <= 2'd0;
						end else begin
							ul_sel_q <= 2'd2;
						end
						state_q <= S_ULRD;
					end
				end
				S_ULRD: begin
					if (ul_go) begin
						state_q <= S_ULWR;
					end else begin
						ul_sel_q <= ul_sel_q + 2'd1;
					end
				end
				S_ULWR: begin
					live_q[ul_t]    <= 1'b0;
					has_alt_q[ul_t] <= 1'b0;
					live_cnt_q      <= live_cnt_q - CNT_W'(1);
					if (ul_sel_q == 2'd2) begin
						head_q   <= next_rd_q;
						pc_cnt_q <= 2'd0;
						state_q  <= S_PC;
					end else begin
						ul_sel_q <= ul_sel_q + 2'd1;
						state_q  <= S_ULRD;
					end
				end
				S_PC: begin
					// split geometry, one add or subtract per cycle
					pc_cnt_q <= pc_cnt_q + 2'd1;
					case (pc_cnt_q)
						2'd0: yd_q <= alu_res[POS_W-1:0];
						2'd1: hd_q <= alu_res;
						2'd2: xr_q <= alu_res[POS_W-1:0];
						default: begin
							wr_q    <= alu_res;
							app_k_q <= 2'd0;
							grp_q   <= '0;
							state_q <= S_SCAN;
						end
					endcase
				end
				S_SCAN: begin
					// slots below the last pick are all live, so resume there
					if (grp_any) begin
						slot_q  <= {grp_q, grp_low};
						state_q <= S_APP;
					end else begin
						grp_q <= grp_q + GRP_W'(1);
					end
				end
				S_APP: begin
					live_q[slot_q]    <= 1'b1;
					has_alt_q[slot_q] <= 1'b1;
					live_cnt_q        <= live_cnt_q + CNT_W'(1);
					case (app_k_q)
						2'd0:    s0_q <= slot_q;
						2'd1:    s1_q <= slot_q;
						2'd2:    s2_q <= slot_q;
						default: s3_q <= slot_q;
					endcase
					if (live_cnt_q == '0) begin
						head_q <= slot_q;
						if (app_k_q == 2'd3) begin
							lk_q    <= 2'd0;
							state_q <= S_LINK;
						end else begin
							app_k_q <= app_k_q + 2'd1;
							state_q <= S_SCAN;
						end
					end else begin
						state_q <= S_TL;
					end
				end
				S_TL: begin
					tail_q  <= prev_rd_q;
					state_q <= S_WB;
				end
				S_WB: begin
					if (app_k_q == 2'd3) begin
						lk_q    <= 2'd0;
						state_q <= S_LINK;
					end else begin
						app_k_q <= app_k_q + 2'd1;
						state_q <= S_SCAN;
					end
				end
				S_LINK: begin
					lk_q <= lk_q + 2'd1;
					if (lk_q == 2'd3) begin
						status_q <= RSP_PLACED;
						state_q  <= S_DONE;
					end
				end
				S_DONE: begin
					// wait for the response register to free up
					if (rsp_load) begin
						rsp_q.status <= status_q;
						rsp_q.pos_x  <= (status_q == RSP_PLACED) ? x_q : '0;
						rsp_q.pos_y  <= (status_q == RSP_PLACED) ? y_q : '0;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_INIT;
			endcase
		end
	end

	// between requests the ring is never empty and the count is in range
	`GRAC_ASSERT_IMP(a_idle_count, state_q == S_IDLE,
		live_cnt_q != '0 && live_cnt_q <= CNT_W'(FREE_SLOTS))
	// the head always names a live slot when a request can enter
	`GRAC_ASSERT_IMP(a_idle_head, state_q == S_IDLE, live_q[head_q])
	// live bits and the live count agree between requests
	`GRAC_ASSERT_IMP(a_idle_pop, state_q == S_IDLE,
		$countones(live_q) == int'(live_cnt_q))
	// a new piece never lands on a live slot
	`GRAC_ASSERT_IMP(a_app_free, state_q == S_APP, !live_q[slot_q])

endmodule
